>>> src/sacache_pkg.sv
// Package with shared constants and types for the set-associative cache model.
`timescale 1ns / 1ps
package sacache_pkg;
    localparam int MAX_SET_BITS_DEF = 8;
    localparam int MAX_WAYS_DEF = 8;
    localparam int ADDR_WIDTH_DEF = 64;
    localparam int TAG_W = 62;
    localparam int CNT_W = 32;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_STORE = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] OC_HIT = 2'd0;
    localparam logic [1:0] OC_FILL = 2'd1;
    localparam logic [1:0] OC_EVICT = 2'd2;

    localparam logic [1:0] CFG_SET_BITS = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS_USED = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] outcome;
        logic       last;
    } sacache_res_t;
endpackage

>>> src/set_assoc_lru_cache_model_core.sv
// Top level of the tag-only set-associative cache model with true LRU replacement.
//   channel | signals                                        | direction
//   input   | valid, stall, address, mode                     | in
//   result  | out_valid, out_stall, outcome, last, totals     | out
//   config  | cfg_we, cfg_index, cfg_data                     | in
// Each access reads the set row (READ), compares and writes it back (UPD), and then
// holds its result (OUT) until the transfer. A new load, store or modify item is accepted only
// once the previous result has transferred; a modify item passes READ, UPD and OUT twice.
// After reset a clearing pass writes every set row, one per cycle (256 rows at the default set
// count), with valid bits clear and ranks in way order; stall is high during it.
// Totals reset to zero. A stalled result holds the block before the next access starts.
module set_assoc_lru_cache_model_core
    import sacache_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    output logic                  stall,
    input  logic [63:0]           address,
    input  logic [1:0]            mode,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            outcome,
    output logic                  last,
    output logic [CNT_W-1:0]      hits_total,
    output logic [CNT_W-1:0]      misses_total,
    output logic [CNT_W-1:0]      evictions_total,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [5:0]            cfg_data
);
    localparam int RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WW = RW + 1;
    localparam int SBW = $clog2(MAX_SET_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_UPD = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [3:0] set_bits_reg;
    logic [5:0] offset_bits_reg;
    logic [3:0] ways_used_reg;

    logic [1:0] state_reg, state_next;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic two_reg;
    logic [MAX_SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic clr_busy_reg;
    logic [MAX_SET_BITS-1:0] clr_addr_reg;
    logic [CNT_W-1:0] hit_reg, miss_reg, evict_reg;
    sacache_res_t res_reg;

    logic [MAX_WAYS-1:0] rd_valid, wr_valid, mem_wr_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tag, wr_tag, mem_wr_tag;
    logic [MAX_WAYS-1:0][RW-1:0] rd_rank, cur_rank, wr_rank, mem_wr_rank;
    logic [MAX_SET_BITS-1:0] mem_wr_addr;

    // Address split for the registered address.
    logic [SBW-1:0] sb;
    logic [6:0] total;
    logic [63:0] a_ext, shifted;
    logic [MAX_SET_BITS-1:0] set_idx;
    logic [TAG_W-1:0] tag_val;
    logic [SBW+MAX_SET_BITS-1:0] set_mask_w;

    always_comb
    begin
        if ({1'b0, set_bits_reg} > 5'(MAX_SET_BITS))
            sb = SBW'(MAX_SET_BITS);
        else
            sb = SBW'(set_bits_reg);
        total = 7'(offset_bits_reg) + 7'(sb);
        a_ext = 64'(addr_reg);
        shifted = a_ext >> offset_bits_reg;
        set_mask_w = ((SBW+MAX_SET_BITS)'(1) << sb) - 1'b1;
        set_idx = shifted[MAX_SET_BITS-1:0] & set_mask_w[MAX_SET_BITS-1:0];
        if (total >= 7'd64)
            tag_val = '0;
        else
            tag_val = TAG_W'(a_ext >> total[5:0]);
    end

    logic [WW-1:0] nw;
    always_comb
    begin
        if (ways_used_reg == 4'd0)
            nw = WW'(1);
        else if ({1'b0, ways_used_reg} > 5'(MAX_WAYS))
            nw = WW'(MAX_WAYS);
        else
            nw = WW'(ways_used_reg);
    end

    // Compare and update of the row read in the previous cycle.
    logic hit, has_empty;
    logic [RW-1:0] hit_way, empty_way, lru_way, victim, sel_way;
    logic [MAX_WAYS-1:0] vrow;
    logic [1:0] oc;

    always_comb
    begin
        vrow = rd_valid;
        cur_rank = rd_rank;
        hit = 1'b0;
        hit_way = '0;
        has_empty = 1'b0;
        empty_way = '0;
        lru_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (WW'(i) < nw)
            begin
                if (vrow[i] && rd_tag[i] == tag_reg)
                begin
                    hit = 1'b1;
                    hit_way = RW'(i);
                end
                if (!vrow[i])
                begin
                    has_empty = 1'b1;
                    empty_way = RW'(i);
                end
            end
        end
        for (int i = 1; i < MAX_WAYS; i++)
            if (WW'(i) < nw && cur_rank[i] > cur_rank[lru_way])
                lru_way = RW'(i);
        victim = has_empty ? empty_way : lru_way;
        sel_way = hit ? hit_way : victim;
        oc = hit ? OC_HIT : (has_empty ? OC_FILL : OC_EVICT);
        wr_valid = vrow;
        wr_valid[sel_way] = 1'b1;
        wr_tag = rd_tag;
        if (!hit)
            wr_tag[sel_way] = tag_reg;
        for (int i = 0; i < MAX_WAYS; i++)
            wr_rank[i] = (cur_rank[i] < cur_rank[sel_way]) ? cur_rank[i] + 1'b1 : cur_rank[i];
        wr_rank[sel_way] = '0;
    end

    logic accept_in, rd_en, wr_en;
    assign accept_in = valid && !stall;
    assign stall = clr_busy_reg || (state_reg != ST_IDLE);
    assign rd_en = (state_reg == ST_READ);
    assign wr_en = clr_busy_reg || (state_reg == ST_UPD);

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_wr_addr = clr_addr_reg;
            mem_wr_valid = '0;
            mem_wr_tag = '0;
            for (int i = 0; i < MAX_WAYS; i++)
                mem_wr_rank[i] = RW'(i);
        end
        else
        begin
            mem_wr_addr = set_reg;
            mem_wr_valid = wr_valid;
            mem_wr_tag = wr_tag;
            mem_wr_rank = wr_rank;
        end
    end

    sacache_set_mem #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS(MAX_WAYS),
        .RW(RW)
    ) u_mem (
        .clk(clk),
        .rd_en(rd_en),
        .rd_addr(set_idx),
        .rd_valid(rd_valid),
        .rd_tag(rd_tag),
        .rd_rank(rd_rank),
        .wr_en(wr_en),
        .wr_addr(mem_wr_addr),
        .wr_valid(mem_wr_valid),
        .wr_tag(mem_wr_tag),
        .wr_rank(mem_wr_rank)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept_in && mode != MODE_NONE)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_UPD;
            ST_UPD:
                state_next = ST_OUT;
            ST_OUT:
                if (!out_stall)
                    state_next = res_reg.last ? ST_IDLE : ST_READ;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            set_bits_reg <= 4'd4;
            offset_bits_reg <= 6'd4;
            ways_used_reg <= 4'd2;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            hit_reg <= '0;
            miss_reg <= '0;
            evict_reg <= '0;
            res_reg <= '0;
            two_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                    clr_busy_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SET_BITS: set_bits_reg <= cfg_data[3:0];
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    CFG_WAYS_USED: ways_used_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && accept_in)
                two_reg <= (mode == MODE_MODIFY);
            if (state_reg == ST_OUT && !out_stall)
            begin
                res_reg.valid <= 1'b0;
                two_reg <= 1'b0;
            end
            if (state_reg == ST_UPD)
            begin
                if (hit)
                    hit_reg <= (hit_reg == '1) ? hit_reg : hit_reg + 1'b1;
                else
                    miss_reg <= (miss_reg == '1) ? miss_reg : miss_reg + 1'b1;
                if (!hit && !has_empty)
                    evict_reg <= (evict_reg == '1) ? evict_reg : evict_reg + 1'b1;
                res_reg.valid <= 1'b1;
                res_reg.outcome <= oc;
                res_reg.last <= !two_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept_in)
            addr_reg <= address[ADDR_WIDTH-1:0];
        if (state_reg == ST_READ)
        begin
            set_reg <= set_idx;
            tag_reg <= tag_val;
        end
    end

    assign out_valid = res_reg.valid;
    assign outcome = res_reg.outcome;
    assign last = res_reg.last;
    assign hits_total = hit_reg;
    assign misses_total = miss_reg;
    assign evictions_total = evict_reg;
endmodule

>>> src/sacache_set_mem.sv
// Set memory: one row per set holding valid bits, tags and age ranks of all ways.
`timescale 1ns / 1ps
module sacache_set_mem
    import sacache_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF,
    parameter int RW = 4
)
(
    input  logic                                 clk,
    input  logic                                 rd_en,
    input  logic [MAX_SET_BITS-1:0]              rd_addr,
    output logic [MAX_WAYS-1:0]                  rd_valid,
    output logic [MAX_WAYS-1:0][TAG_W-1:0]       rd_tag,
    output logic [MAX_WAYS-1:0][RW-1:0]          rd_rank,
    input  logic                                 wr_en,
    input  logic [MAX_SET_BITS-1:0]              wr_addr,
    input  logic [MAX_WAYS-1:0]                  wr_valid,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]       wr_tag,
    input  logic [MAX_WAYS-1:0][RW-1:0]          wr_rank
);
    localparam int DEPTH = 1 << MAX_SET_BITS;

    logic [MAX_WAYS-1:0]            valid_mem [DEPTH];
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [DEPTH];
    logic [MAX_WAYS-1:0][RW-1:0]    rank_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            valid_mem[wr_addr] <= wr_valid;
            tag_mem[wr_addr] <= wr_tag;
            rank_mem[wr_addr] <= wr_rank;
        end
        if (rd_en)
        begin
            rd_valid <= valid_mem[rd_addr];
            rd_tag <= tag_mem[rd_addr];
            rd_rank <= rank_mem[rd_addr];
        end
    end
endmodule
